// ===== sv/point_in_polygon_crossing_test_macros.svh =====
// Assertion macros for the point-in-polygon crossing test.
// Each macro expands to one labeled concurrent assertion on the rising clock edge,
// disabled while reset is high.
`ifndef POINT_IN_POLYGON_CROSSING_TEST_MACROS_SVH
`define POINT_IN_POLYGON_CROSSING_TEST_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PIPCT_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PIPCT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== sv/pipct_pkg.sv =====
// ----------------------------------------------------------------------------
// pipct_pkg
// Shared constants and controller/datapath interface types of the
// point-in-polygon crossing test.
// ----------------------------------------------------------------------------
package pipct_pkg;

   localparam int COORD_BITS_DEF = 16;
   localparam int FRAC_BITS      = 16;
   localparam int ROUND_HALF     = 32'h8000;
   localparam int MUL_CHUNK      = 8;

   localparam int                  CROSS_BITS   = 2;
   localparam logic [CROSS_BITS-1:0] CROSS_SAT    = 2'd2;
   localparam logic [CROSS_BITS-1:0] CROSS_INSIDE = 2'd1;

   localparam logic [1:0] PLANE_XY = 2'd0;
   localparam logic [1:0] PLANE_XZ = 2'd1;
   localparam logic [1:0] PLANE_YZ = 2'd2;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;        // transfer accepted: project, latch, set up the open edge
      logic eval;        // classify the current edge, set up the divider
      logic div_step;    // one quotient bit
      logic mul_step;    // one multiplier chunk
      logic finish;      // round the intersection and compare
      logic load_close;  // set up the closing edge back to the first vertex
      logic emit;        // load the result register
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic straddle;     // edge crosses the line and straddles the query point
      logic step_last;    // divider or multiplier is on its final step
      logic last_vertex;  // current vertex closes the polygon
   } status_type;

endpackage

// ===== sv/pipct_controller.sv =====
// ----------------------------------------------------------------------------
// pipct_controller
// Sequencer for the crossing test: edge classification, the serial divider,
// the chunked multiplier, the closing edge and the result register.
// ----------------------------------------------------------------------------
module pipct_controller
   import pipct_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output cmd_type    cmd,
   input  status_type status
);

   typedef enum logic [6:0] {
      ST_IDLE  = 7'b0000001,
      ST_EVAL  = 7'b0000010,
      ST_DIV   = 7'b0000100,
      ST_MUL   = 7'b0001000,
      ST_FIN   = 7'b0010000,
      ST_CLOSE = 7'b0100000,
      ST_RESP  = 7'b1000000
   } state_type;

   state_type state_ff, state_in;
   state_type edge_done_state;
   logic      close_ff, close_in;
   logic      rsp_valid_ff, rsp_valid_in;

   // Where to go once the current edge has been counted.
   always_comb begin
      if (close_ff) begin
         edge_done_state = ST_RESP;
      end else if (status.last_vertex) begin
         edge_done_state = ST_CLOSE;
      end else begin
         edge_done_state = ST_IDLE;
      end
   end

   always_comb begin
      state_in = state_ff;
      close_in = close_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               close_in = 1'b0;
               state_in = ST_EVAL;
            end
         end
         ST_EVAL: begin
            cmd.eval = 1'b1;
            state_in = status.straddle ? ST_DIV : edge_done_state;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (status.step_last) begin
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            cmd.mul_step = 1'b1;
            if (status.step_last) begin
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            cmd.finish = 1'b1;
            state_in   = edge_done_state;
         end
         ST_CLOSE: begin
            cmd.load_close = 1'b1;
            close_in       = 1'b1;
            state_in       = ST_EVAL;
         end
         ST_RESP: begin
            // Hold here while the previous result still waits in the output register.
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.emit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         close_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         close_ff     <= close_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

// ===== sv/pipct_datapath.sv =====
// ----------------------------------------------------------------------------
// pipct_datapath
// Projection, polygon state, edge classification, restoring divider,
// chunked multiplier and the rounded intersection compare.
// ----------------------------------------------------------------------------
module pipct_datapath
   import pipct_pkg::*;
#(
   parameter int COORD_BITS = COORD_BITS_DEF
)
(
   input  logic                         clock,
   input  logic                         reset,
   input  cmd_type                      cmd,
   output status_type                   status,
   input  logic [1:0]                   req_plane,
   input  logic signed [COORD_BITS-1:0] req_point_x,
   input  logic signed [COORD_BITS-1:0] req_point_y,
   input  logic signed [COORD_BITS-1:0] req_point_z,
   input  logic signed [COORD_BITS-1:0] req_vert_x,
   input  logic signed [COORD_BITS-1:0] req_vert_y,
   input  logic signed [COORD_BITS-1:0] req_vert_z,
   input  logic                         req_last_vertex,
   output logic                         rsp_inside_res
);

   localparam int W         = COORD_BITS;
   localparam int NW        = W + FRAC_BITS;          // dividend and quotient width
   localparam int PW        = NW + W;                 // product magnitude width
   localparam int MUL_STEPS = (W + MUL_CHUNK - 1) / MUL_CHUNK;
   localparam int CNT_W     = $clog2(NW + 1);
   localparam int OFF_W     = PW + 2 - FRAC_BITS;
   localparam int CMP_W     = OFF_W + 1;

   // Projected operands.
   logic signed [W-1:0] vert_u, vert_v, point_u, point_v;

   // Polygon state.
   logic signed [W-1:0] query_u_ff, query_u_in, query_v_ff, query_v_in;
   logic signed [W-1:0] first_u_ff, first_u_in, first_v_ff, first_v_in;
   logic signed [W-1:0] prev_u_ff, prev_u_in, prev_v_ff, prev_v_in;
   logic [CROSS_BITS-1:0] crossings_ff, crossings_in;
   logic                  awaiting_ff, awaiting_in;
   logic                  last_ff, last_in;

   // Current edge.
   logic signed [W-1:0] e_u0_ff, e_u0_in, e_v0_ff, e_v0_in;
   logic signed [W-1:0] e_u1_ff, e_u1_in, e_v1_ff, e_v1_in;

   // Divider and multiplier.
   logic [NW-1:0]    num_ff, num_in, num_next;
   logic [W-1:0]     rem_ff, rem_in, rem_next;
   logic [W-1:0]     dvs_ff, dvs_in;
   logic [W-1:0]     dqm_ff, dqm_in;
   logic             pneg_ff, pneg_in;
   logic [PW-1:0]    mcand_ff, mcand_in;
   logic [W-1:0]     mplier_ff, mplier_in;
   logic [PW-1:0]    acc_ff, acc_in, acc_next;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             inside_ff, inside_in;

   // Edge classification.
   logic signed [W:0] du, dv, dq, neg_du, neg_dv, neg_dq;
   logic [W-1:0]      du_mag, dv_mag, dq_mag;
   logic              a_above, b_above, u0_right, u1_right, active;
   logic              both_right, straddle;

   // Divider step.
   logic [W:0] div_shift, div_trial;
   logic       div_ge;

   // Multiplier step.
   logic [PW+MUL_CHUNK-1:0] mul_prod;

   // Rounding and compare.
   logic signed [PW:0]      p_mag, p_val;
   logic [PW+1:0]           p_round;
   logic signed [OFF_W-1:0] off;
   logic signed [CMP_W-1:0] cmp_lhs, cmp_rhs;
   logic                    hit;

   always_comb begin
      unique case (req_plane)
         PLANE_XY: begin
            vert_u  = req_vert_x;
            vert_v  = req_vert_y;
            point_u = req_point_x;
            point_v = req_point_y;
         end
         PLANE_XZ: begin
            vert_u  = req_vert_x;
            vert_v  = req_vert_z;
            point_u = req_point_x;
            point_v = req_point_z;
         end
         default: begin
            // The unused selector code projects like the YZ plane.
            vert_u  = req_vert_y;
            vert_v  = req_vert_z;
            point_u = req_point_y;
            point_v = req_point_z;
         end
      endcase
   end

   always_comb begin
      du     = $signed({e_u1_ff[W-1], e_u1_ff}) - $signed({e_u0_ff[W-1], e_u0_ff});
      dv     = $signed({e_v1_ff[W-1], e_v1_ff}) - $signed({e_v0_ff[W-1], e_v0_ff});
      dq     = $signed({query_v_ff[W-1], query_v_ff}) - $signed({e_v0_ff[W-1], e_v0_ff});
      neg_du = -du;
      neg_dv = -dv;
      neg_dq = -dq;
      du_mag = du[W] ? neg_du[W-1:0] : du[W-1:0];
      dv_mag = dv[W] ? neg_dv[W-1:0] : dv[W-1:0];
      dq_mag = dq[W] ? neg_dq[W-1:0] : dq[W-1:0];

      a_above    = (e_v0_ff >= query_v_ff);
      b_above    = (e_v1_ff >= query_v_ff);
      u0_right   = (e_u0_ff >= query_u_ff);
      u1_right   = (e_u1_ff >= query_u_ff);
      active     = (crossings_ff < CROSS_SAT) && (a_above != b_above);
      both_right = active && u0_right && u1_right;
      straddle   = active && (u0_right != u1_right);
   end

   always_comb begin
      div_shift = {rem_ff, num_ff[NW-1]};
      div_trial = div_shift - {1'b0, dvs_ff};
      div_ge    = (div_shift >= {1'b0, dvs_ff});
      rem_next  = div_ge ? div_trial[W-1:0] : div_shift[W-1:0];
      num_next  = {num_ff[NW-2:0], div_ge};

      mul_prod  = mcand_ff * mplier_ff[MUL_CHUNK-1:0];
      acc_next  = acc_ff + mul_prod[PW-1:0];
   end

   // Intersection offset: floor((p + 0x8000) / 2^16), then u0 + offset >= query_u.
   always_comb begin
      p_mag   = $signed({1'b0, acc_ff});
      p_val   = pneg_ff ? -p_mag : p_mag;
      p_round = {p_val[PW], p_val} + (PW+2)'(ROUND_HALF);
      off     = $signed(p_round[PW+1:FRAC_BITS]);
      cmp_lhs = $signed({{(CMP_W-W){e_u0_ff[W-1]}}, e_u0_ff}) + $signed({off[OFF_W-1], off});
      cmp_rhs = $signed({{(CMP_W-W){query_u_ff[W-1]}}, query_u_ff});
      hit     = (cmp_lhs >= cmp_rhs);
   end

   always_comb begin
      query_u_in   = query_u_ff;
      query_v_in   = query_v_ff;
      first_u_in   = first_u_ff;
      first_v_in   = first_v_ff;
      prev_u_in    = prev_u_ff;
      prev_v_in    = prev_v_ff;
      crossings_in = crossings_ff;
      awaiting_in  = awaiting_ff;
      last_in      = last_ff;
      e_u0_in      = e_u0_ff;
      e_v0_in      = e_v0_ff;
      e_u1_in      = e_u1_ff;
      e_v1_in      = e_v1_ff;
      num_in       = num_ff;
      rem_in       = rem_ff;
      dvs_in       = dvs_ff;
      dqm_in       = dqm_ff;
      pneg_in      = pneg_ff;
      mcand_in     = mcand_ff;
      mplier_in    = mplier_ff;
      acc_in       = acc_ff;
      cnt_in       = cnt_ff;
      inside_in    = inside_ff;

      if (cmd.load) begin
         // The first vertex opens a degenerate edge onto itself, which never counts.
         if (awaiting_ff) begin
            query_u_in   = point_u;
            query_v_in   = point_v;
            first_u_in   = vert_u;
            first_v_in   = vert_v;
            crossings_in = '0;
            awaiting_in  = 1'b0;
            e_u0_in      = vert_u;
            e_v0_in      = vert_v;
         end else begin
            e_u0_in = prev_u_ff;
            e_v0_in = prev_v_ff;
         end
         e_u1_in   = vert_u;
         e_v1_in   = vert_v;
         prev_u_in = vert_u;
         prev_v_in = vert_v;
         last_in   = req_last_vertex;
      end

      if (cmd.load_close) begin
         e_u0_in = prev_u_ff;
         e_v0_in = prev_v_ff;
         e_u1_in = first_u_ff;
         e_v1_in = first_v_ff;
      end

      if (cmd.eval) begin
         if (both_right) begin
            crossings_in = crossings_ff + 1'b1;
         end
         num_in  = {du_mag, {FRAC_BITS{1'b0}}};
         rem_in  = '0;
         dvs_in  = dv_mag;
         dqm_in  = dq_mag;
         pneg_in = du[W] ^ dv[W] ^ dq[W];
         cnt_in  = CNT_W'(NW - 1);
      end

      if (cmd.div_step) begin
         num_in = num_next;
         rem_in = rem_next;
         if (cnt_ff == '0) begin
            mcand_in  = PW'(num_next);
            mplier_in = dqm_ff;
            acc_in    = '0;
            cnt_in    = CNT_W'(MUL_STEPS - 1);
         end else begin
            cnt_in = cnt_ff - 1'b1;
         end
      end

      if (cmd.mul_step) begin
         acc_in    = acc_next;
         mcand_in  = mcand_ff << MUL_CHUNK;
         mplier_in = mplier_ff >> MUL_CHUNK;
         if (cnt_ff != '0) begin
            cnt_in = cnt_ff - 1'b1;
         end
      end

      if (cmd.finish && hit) begin
         crossings_in = crossings_ff + 1'b1;
      end

      if (cmd.emit) begin
         inside_in   = (crossings_ff == CROSS_INSIDE);
         awaiting_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         crossings_ff <= '0;
         awaiting_ff  <= 1'b1;
         last_ff      <= 1'b0;
         cnt_ff       <= '0;
      end else begin
         crossings_ff <= crossings_in;
         awaiting_ff  <= awaiting_in;
         last_ff      <= last_in;
         cnt_ff       <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      query_u_ff <= query_u_in;
      query_v_ff <= query_v_in;
      first_u_ff <= first_u_in;
      first_v_ff <= first_v_in;
      prev_u_ff  <= prev_u_in;
      prev_v_ff  <= prev_v_in;
      e_u0_ff    <= e_u0_in;
      e_v0_ff    <= e_v0_in;
      e_u1_ff    <= e_u1_in;
      e_v1_ff    <= e_v1_in;
      num_ff     <= num_in;
      rem_ff     <= rem_in;
      dvs_ff     <= dvs_in;
      dqm_ff     <= dqm_in;
      pneg_ff    <= pneg_in;
      mcand_ff   <= mcand_in;
      mplier_ff  <= mplier_in;
      acc_ff     <= acc_in;
      inside_ff  <= inside_in;
   end

   assign status.straddle    = straddle;
   assign status.step_last   = (cnt_ff == '0);
   assign status.last_vertex = last_ff;
   assign rsp_inside_res     = inside_ff;

endmodule

// ===== sv/point_in_polygon_crossing_test.sv =====
// ----------------------------------------------------------------------------
// point_in_polygon_crossing_test: edge-by-edge crossing-number test, one vertex per transfer.
// A vertex is taken only while idle, once the edge of the previous one is done; a straddling
// edge adds the serial divider steps, the chunked multiplier steps and a compare step.
// After the last vertex, its edge and then the closing edge are classified, and rsp_valid
// rises from the result register once the output register is free.
// Reset (synchronous): idle, no result pending, next transfer opens a new polygon.
// ----------------------------------------------------------------------------
module point_in_polygon_crossing_test
   import pipct_pkg::*;
#(
   parameter int COORD_BITS = COORD_BITS_DEF
)
(
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [1:0]                   req_plane,
   input  logic signed [COORD_BITS-1:0] req_point_x,
   input  logic signed [COORD_BITS-1:0] req_point_y,
   input  logic signed [COORD_BITS-1:0] req_point_z,
   input  logic signed [COORD_BITS-1:0] req_vert_x,
   input  logic signed [COORD_BITS-1:0] req_vert_y,
   input  logic signed [COORD_BITS-1:0] req_vert_z,
   input  logic                         req_last_vertex,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic                         rsp_inside_res
);

   `include "point_in_polygon_crossing_test_macros.svh"

   cmd_type    cmd;
   status_type status;

   pipct_controller u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd),
      .status    (status)
   );

   pipct_datapath #(
      .COORD_BITS (COORD_BITS)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .req_plane       (req_plane),
      .req_point_x     (req_point_x),
      .req_point_y     (req_point_y),
      .req_point_z     (req_point_z),
      .req_vert_x      (req_vert_x),
      .req_vert_y      (req_vert_y),
      .req_vert_z      (req_vert_z),
      .req_last_vertex (req_last_vertex),
      .rsp_inside_res  (rsp_inside_res)
   );

   // Every accepted transfer is followed by the classification of its edge.
   `PIPCT_ASSERT_NEXT(a_accept_then_eval, clock, reset, req_valid && req_ready, cmd.eval, "accepted vertex not evaluated")

   // A new result never overwrites one that is still waiting.
   `PIPCT_ASSERT_SAME(a_no_result_overwrite, clock, reset, cmd.emit, !rsp_valid || rsp_ready, "pending result overwritten")

   // The divider hands over to the multiplier after its final step.
   `PIPCT_ASSERT_NEXT(a_div_then_mul, clock, reset, cmd.div_step && status.step_last, cmd.mul_step, "multiplier did not follow divider")

   // While ready, no arithmetic of an earlier vertex is still running.
   `PIPCT_ASSERT_SAME(a_ready_quiet, clock, reset, req_ready, !(cmd.eval || cmd.div_step || cmd.mul_step || cmd.finish), "busy while ready")

endmodule

// ===== test/polygon_inside_checker.sv =====
// ----------------------------------------------------------------------------
// polygon_inside_checker
// Watches the vertex and result channels of the point-in-polygon crossing
// test. It keeps its own copy of the polygon state, predicts the inside flag
// for every closed polygon, and compares each result transfer in order.
// ----------------------------------------------------------------------------
module polygon_inside_checker
   import pipct_pkg::*;
(
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   input  logic                             req_ready,
   input  logic [1:0]                       req_plane,
   input  logic signed [COORD_BITS_DEF-1:0] req_point_x,
   input  logic signed [COORD_BITS_DEF-1:0] req_point_y,
   input  logic signed [COORD_BITS_DEF-1:0] req_point_z,
   input  logic signed [COORD_BITS_DEF-1:0] req_vert_x,
   input  logic signed [COORD_BITS_DEF-1:0] req_vert_y,
   input  logic signed [COORD_BITS_DEF-1:0] req_vert_z,
   input  logic                             req_last_vertex,
   input  logic                             rsp_valid,
   input  logic                             rsp_ready,
   input  logic                             rsp_inside_res,
   output int                               fail_count,
   output int                               results_pending
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef logic signed [COORD_BITS_DEF-1:0] coord_t;

   coord_t                first_u, first_v, prev_u, prev_v, query_u, query_v;
   logic [CROSS_BITS-1:0] crossings;
   logic                  awaiting_first;
   logic                  inside_q[$];

   // Planes other than XY and XZ, the spare code included, project onto YZ.
   function automatic void project_onto_plane(input logic [1:0] pl, input coord_t x, y, z,
                                              output coord_t u, v);
      case (pl)
         PLANE_XY: begin
            u = x;
            v = y;
         end
         PLANE_XZ: begin
            u = x;
            v = z;
         end
         default: begin
            u = y;
            v = z;
         end
      endcase
   endfunction

   // Crossing test of one edge against the horizontal line through the query point.
   function automatic void count_crossing(input coord_t u0, v0, u1, v1);
      longint dv, q, p, off;
      logic   hit;
      hit = 1'b0;
      if (crossings >= CROSS_SAT || ((v0 >= query_v) == (v1 >= query_v)))
         return;
      if (u0 >= query_u && u1 >= query_u) begin
         hit = 1'b1;
      end else if (u0 >= query_u || u1 >= query_u) begin
         // The ends straddle the line, so dv is never zero here and the
         // product stays well inside 64 bits.
         dv  = longint'(v1) - longint'(v0);
         q   = ((longint'(u1) - longint'(u0)) <<< FRAC_BITS) / dv;
         p   = (q * ((longint'(query_v) - longint'(v0)) <<< FRAC_BITS)) >>> FRAC_BITS;
         off = (p + longint'(ROUND_HALF)) >>> FRAC_BITS;
         hit = (longint'(u0) + off) >= longint'(query_u);
      end
      if (hit)
         crossings = crossings + 1'b1;
   endfunction

   always @(posedge clock) begin : watch
      coord_t vu, vv;
      logic   expected;
      if (reset) begin
         first_u        = '0;
         first_v        = '0;
         prev_u         = '0;
         prev_v         = '0;
         query_u        = '0;
         query_v        = '0;
         crossings      = '0;
         awaiting_first = 1'b1;
         fail_count     = 0;
         inside_q.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (inside_q.size() == 0) begin
               $display("%0t: unexpected result transfer, expected none, got inside_res %0b",
                        $time, rsp_inside_res);
               fail_count++;
            end else begin
               expected = inside_q.pop_front();
               if (rsp_inside_res !== expected) begin
                  $display("%0t: inside_res mismatch, expected %0b, got %0b",
                           $time, expected, rsp_inside_res);
                  fail_count++;
               end
            end
         end
         if (req_valid && req_ready) begin
            project_onto_plane(req_plane, req_vert_x, req_vert_y, req_vert_z, vu, vv);
            if (awaiting_first) begin
               project_onto_plane(req_plane, req_point_x, req_point_y, req_point_z,
                                  query_u, query_v);
               first_u        = vu;
               first_v        = vv;
               crossings      = '0;
               awaiting_first = 1'b0;
            end else begin
               count_crossing(prev_u, prev_v, vu, vv);
            end
            prev_u = vu;
            prev_v = vv;
            if (req_last_vertex) begin
               count_crossing(vu, vv, first_u, first_v);
               inside_q.push_back(crossings == CROSS_INSIDE);
               awaiting_first = 1'b1;
            end
         end
      end
      results_pending = inside_q.size();
   end

endmodule

// ===== test/point_in_polygon_crossing_test_test.sv =====
// ----------------------------------------------------------------------------
// point_in_polygon_crossing_test_test
// Feeds polygons vertex by vertex into the crossing test: a directed set of
// corner cases first, then random polygons under three idling patterns. The
// checker beside the block predicts and compares every inside flag.
// ----------------------------------------------------------------------------
module point_in_polygon_crossing_test_test;
   import pipct_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   typedef logic signed [COORD_BITS_DEF-1:0] coord_t;

   localparam logic [1:0] PLANE_SPARE = 2'd3;
   localparam coord_t     COORD_MAX   = coord_t'((1 << (COORD_BITS_DEF - 1)) - 1);
   localparam coord_t     COORD_MIN   = ~COORD_MAX;
   localparam int         PHASE_ITEMS = 400;

   logic       clock           = 1'b0;
   logic       reset           = 1'b1;
   logic       req_valid       = 1'b0;
   logic       req_ready;
   logic [1:0] req_plane       = PLANE_XY;
   coord_t     req_point_x     = '0;
   coord_t     req_point_y     = '0;
   coord_t     req_point_z     = '0;
   coord_t     req_vert_x      = '0;
   coord_t     req_vert_y      = '0;
   coord_t     req_vert_z      = '0;
   logic       req_last_vertex = 1'b0;
   logic       rsp_valid;
   logic       rsp_ready       = 1'b0;
   logic       rsp_inside_res;
   int         fail_count;
   int         results_pending;

   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int vertices_sent = 0;

   point_in_polygon_crossing_test DUT (.*);

   polygon_inside_checker inside_checker (.*);

   always #6 clock = ~clock;

   always @(negedge clock)
      rsp_ready <= ($urandom_range(99) >= recv_idle_pct);

   initial begin
      #10_000_000;
      $display("FAIL point_in_polygon_crossing_test");
      $finish;
   end

   task automatic send_vertex(input logic [1:0] pl, input coord_t px, py, pz, vx, vy, vz,
                              input logic last);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_plane       <= pl;
      req_point_x     <= px;
      req_point_y     <= py;
      req_point_z     <= pz;
      req_vert_x      <= vx;
      req_vert_y      <= vy;
      req_vert_z      <= vz;
      req_last_vertex <= last;
      req_valid       <= 1'b1;
      do @(posedge clock); while (!req_ready);
      vertices_sent++;
   endtask

   // Hold the sender off until every predicted result has been seen.
   task automatic drain();
      @(negedge clock);
      req_valid <= 1'b0;
      wait (results_pending == 0);
   endtask

   function automatic coord_t jitter(input coord_t c, input int r);
      return c + coord_t'(int'($urandom_range(2 * r)) - r);
   endfunction

   function automatic coord_t pick_extreme(input coord_t c);
      case ($urandom_range(4))
         0: return COORD_MIN;
         1: return COORD_MAX;
         2: return '0;
         3: return '1;
         default: return c;
      endcase
   endfunction

   task automatic send_random_polygon();
      int         n, style, radius;
      int         radii[4];
      logic [1:0] pl;
      coord_t     px, py, pz, qx, qy, qz, vx, vy, vz;
      radii = '{4, 64, 2000, 20000};
      case ($urandom_range(9))
         0:       n = $urandom_range(1, 2);
         1, 2:    n = $urandom_range(7, 12);
         default: n = $urandom_range(3, 6);
      endcase
      pl     = ($urandom_range(9) == 0) ? PLANE_SPARE : 2'($urandom_range(2));
      style  = $urandom_range(99);
      radius = radii[$urandom_range(3)];
      px     = coord_t'($urandom);
      py     = coord_t'($urandom);
      pz     = coord_t'($urandom);
      for (int k = 0; k < n; k++) begin
         if (style < 70) begin
            vx = jitter(px, radius);
            vy = jitter(py, radius);
            vz = jitter(pz, radius);
         end else if (style < 85) begin
            vx = coord_t'($urandom);
            vy = coord_t'($urandom);
            vz = coord_t'($urandom);
         end else begin
            vx = pick_extreme(px);
            vy = pick_extreme(py);
            vz = pick_extreme(pz);
         end
         // After the first vertex the point fields and, now and then, the plane
         // may change; only the point of the first vertex counts.
         qx = px;
         qy = py;
         qz = pz;
         if (k > 0) begin
            if ($urandom_range(19) == 0)
               pl = 2'($urandom_range(3));
            if ($urandom_range(9) < 3) begin
               qx = coord_t'($urandom);
               qy = coord_t'($urandom);
               qz = coord_t'($urandom);
            end
         end
         send_vertex(pl, qx, qy, qz, vx, vy, vz, k == n - 1);
      end
   endtask

   task automatic run_phase(input int send_pct, input int recv_pct);
      int start;
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
      start         = vertices_sent;
      while (vertices_sent - start < PHASE_ITEMS)
         send_random_polygon();
      drain();
   endtask

   initial begin
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // A lone vertex closes onto itself and can never be inside.
      send_vertex(PLANE_XY, '0, '0, '0, 16'sd5, 16'sd5, '0, 1'b1);
      // Triangle around the point, one edge straddling it.
      send_vertex(PLANE_XY, '0, '0, '0, -16'sd100, -16'sd100, 16'sd7, 1'b0);
      send_vertex(PLANE_XY, '0, '0, '0, 16'sd100, -16'sd100, 16'sd7, 1'b0);
      send_vertex(PLANE_XY, '0, '0, '0, '0, 16'sd100, 16'sd7, 1'b1);
      // Same triangle with the point to its right.
      send_vertex(PLANE_XY, 16'sd200, '0, '0, -16'sd100, -16'sd100, '0, 1'b0);
      send_vertex(PLANE_XY, 16'sd200, '0, '0, 16'sd100, -16'sd100, '0, 1'b0);
      send_vertex(PLANE_XY, 16'sd200, '0, '0, '0, 16'sd100, '0, 1'b1);
      // Full-range triangle on the XZ plane.
      send_vertex(PLANE_XZ, '0, 16'sd1234, '0, COORD_MIN, 16'sd99, COORD_MIN, 1'b0);
      send_vertex(PLANE_XZ, '0, 16'sd1234, '0, COORD_MAX, 16'sd99, COORD_MIN, 1'b0);
      send_vertex(PLANE_XZ, '0, 16'sd1234, '0, '0, 16'sd99, COORD_MAX, 1'b1);
      // Spare plane code, then a change of plane inside the polygon.
      send_vertex(PLANE_SPARE, 16'sd3, 16'sd10, 16'sd10, '0, -16'sd50, -16'sd50, 1'b0);
      send_vertex(PLANE_YZ, 16'sd3, 16'sd10, 16'sd10, '0, 16'sd50, '0, 1'b0);
      send_vertex(PLANE_XY, 16'sd3, 16'sd10, 16'sd10, -16'sd50, 16'sd50, '0, 1'b0);
      send_vertex(PLANE_SPARE, 16'sd3, 16'sd10, 16'sd10, '0, -16'sd60, 16'sd40, 1'b1);
      // Horizontal edge lying on the line through the point.
      send_vertex(PLANE_XY, '0, '0, '0, -16'sd10, '0, '0, 1'b0);
      send_vertex(PLANE_XY, '0, '0, '0, 16'sd10, '0, '0, 1'b0);
      send_vertex(PLANE_XY, '0, '0, '0, '0, 16'sd20, '0, 1'b1);
      // Two vertices: the edge and its closing twin both cross.
      send_vertex(PLANE_XY, '0, '0, '0, 16'sd5, -16'sd5, '0, 1'b0);
      send_vertex(PLANE_XY, '0, '0, '0, 16'sd5, 16'sd5, '0, 1'b1);
      // Zigzag whose crossings pass the saturation point.
      send_vertex(PLANE_XY, '0, '0, '0, 16'sd10, -16'sd10, '0, 1'b0);
      send_vertex(PLANE_XY, '0, '0, '0, 16'sd20, 16'sd10, '0, 1'b0);
      send_vertex(PLANE_XY, '0, '0, '0, 16'sd30, -16'sd10, '0, 1'b0);
      send_vertex(PLANE_XY, '0, '0, '0, 16'sd40, 16'sd10, '0, 1'b1);
      // Point and vertices at the corners of the coordinate range.
      send_vertex(PLANE_XY, COORD_MIN, COORD_MAX, COORD_MIN, COORD_MIN, COORD_MAX, '0, 1'b0);
      send_vertex(PLANE_XY, COORD_MIN, COORD_MAX, COORD_MIN, COORD_MAX, COORD_MIN, '0, 1'b0);
      send_vertex(PLANE_XY, COORD_MIN, COORD_MAX, COORD_MIN, COORD_MAX, COORD_MAX, '1, 1'b1);
      drain();

      run_phase(35, 75);
      run_phase(75, 35);
      run_phase(0, 0);

      wait (results_pending == 0);
      repeat (100) @(posedge clock);
      if (fail_count == 0)
         $display("PASS point_in_polygon_crossing_test");
      else
         $display("FAIL point_in_polygon_crossing_test");
      $finish;
   end

endmodule

// ===== sim.f =====
+incdir+sv
sv/pipct_pkg.sv
sv/pipct_controller.sv
sv/pipct_datapath.sv
sv/point_in_polygon_crossing_test.sv
test/polygon_inside_checker.sv
test/point_in_polygon_crossing_test_test.sv
